/* hdl/bbb_pkg.sv */
// ----------------------------------------------------------------------------
// bbb_pkg: shared types and constants of the blank border bounding box
// Geometry limits, register indexes, and the structs passed between modules.
// ----------------------------------------------------------------------------
package bbb_pkg;

  // geometry limits and alignment (ALIGN is a power of two)
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int ALIGN_LOG2 = 2;
  localparam int ALIGN      = 1 << ALIGN_LOG2;

  // field widths
  localparam int PIX_W  = 8;
  localparam int CFG_W  = 11;
  localparam int IDX_W  = 3;
  localparam int WIN_W  = 10;
  localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int CR_W   = (COL_W > ROW_W) ? COL_W : ROW_W;
  localparam int XW     = (CR_W > WIN_W) ? CR_W : WIN_W;
  // alignment arithmetic: room for right edge plus padding
  localparam int EXT_W  = COL_W + ALIGN_LOG2 + 1;

  localparam logic [PIX_W-1:0] BLANK_PIX = '1;

  // configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_FRAME_WIDTH  = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_WIN_X_LO     = 3'd2,
    REG_WIN_X_HI     = 3'd3,
    REG_WIN_Y_LO     = 3'd4,
    REG_WIN_Y_HI     = 3'd5
  } bbb_reg_e;

  // decoded configuration: last column/row index after clamping
  typedef struct packed {
    logic [COL_W-1:0] fw_last;
    logic [ROW_W-1:0] fh_last;
    logic [WIN_W-1:0] x_lo;
    logic [WIN_W-1:0] x_hi;
    logic [WIN_W-1:0] y_lo;
    logic [WIN_W-1:0] y_hi;
  } bbb_cfg_t;

  // tracking state seen at the last pixel of a frame
  typedef struct packed {
    logic             found_col;
    logic [ROW_W-1:0] top_row;
    logic [ROW_W-1:0] bottom_row;
    logic [COL_W-1:0] left_col;
    logic [COL_W-1:0] right_col;
  } bbb_box_t;

  // one result transaction
  typedef struct packed {
    logic             empty_res;
    logic [WIN_W-1:0] row_first;
    logic [WIN_W-1:0] row_last;
    logic [WIN_W-1:0] col_first;
    logic [WIN_W-1:0] col_last;
  } bbb_res_t;

  // last index of a dimension: 0 taken as 1, above maxv taken as maxv
  function automatic int clamp_last(logic [CFG_W-1:0] v, int maxv);
    int r;
    if (v == '0) begin
      r = 0;
    end else if (int'(v) > maxv) begin
      r = maxv - 1;
    end else begin
      r = int'(v) - 1;
    end
    return r;
  endfunction

endpackage

/* hdl/blank_border_bounding_box.sv */
// ----------------------------------------------------------------------------
// blank_border_bounding_box: bounding box of non-blank pixels in a frame
// Finds the rows and aligned columns that hold non-blank pixels and reports
// the box once per frame.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o): one pixel per transaction in
//   raster order; frame_start_i marks column 0, row 0 and restarts the
//   counters. Frames of the configured size may also follow back to back.
//   Output channel (out_valid_o / out_stall_i): one result transaction per
//   frame, issued for the last pixel of the frame.
//   Configuration (cfg_we_i, cfg_idx_i, cfg_data_i): single-cycle writes,
//   done while the block is idle.
// Timing:
//   One pixel per clock sustained unless a stalled result holds a last pixel.
//   The counter and edge update is done on the pixel in the input register;
//   the result is loaded into the output register as the last pixel leaves it.
// Reset: all counters and tracking state clear; registers take their
//   defaults (1024 x 1024 frame, full windows).
// Stall: a waiting result holds the output register; pixels that end no
//   frame keep flowing, and the last pixel of the next frame waits in the
//   input register until the result is taken.
// ----------------------------------------------------------------------------
module blank_border_bounding_box (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [bbb_pkg::IDX_W-1:0]  cfg_idx_i,
  input  logic [bbb_pkg::CFG_W-1:0]  cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [bbb_pkg::PIX_W-1:0]  pixel_i,
  input  logic                       frame_start_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       empty_res_o,
  output logic [bbb_pkg::WIN_W-1:0]  row_first_o,
  output logic [bbb_pkg::WIN_W-1:0]  row_last_o,
  output logic [bbb_pkg::WIN_W-1:0]  col_first_o,
  output logic [bbb_pkg::WIN_W-1:0]  col_last_o
);
  import bbb_pkg::*;

  bbb_cfg_t         cfg;
  bbb_box_t         box;
  logic             is_last;
  logic             fire, in_accept, out_load;
  logic [COL_W-1:0] left_al, right_al;

  logic             in_valid_q, in_valid_d;
  logic [PIX_W-1:0] pixel_q;
  logic             frame_start_q;
  logic             out_valid_q, out_valid_d;
  bbb_res_t         res_q, res_d;

  // configuration registers
  bbb_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // handshake: a frame-ending pixel needs a free output register
  assign fire       = in_valid_q && (!is_last || !(out_valid_q && out_stall_i));
  assign in_stall_o = in_valid_q && !fire;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_load   = fire && is_last;

  // input register
  assign in_valid_d = in_accept ? 1'b1 : (fire ? 1'b0 : in_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      pixel_q       <= pixel_i;
      frame_start_q <= frame_start_i;
    end
  end

  // counters and edge tracking
  bbb_track u_track (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .advance_i     (fire),
    .pixel_i       (pixel_q),
    .frame_start_i (frame_start_q),
    .is_last_o     (is_last),
    .box_o         (box)
  );

  // column alignment
  bbb_align u_align (
    .left_i    (box.left_col),
    .right_i   (box.right_col),
    .fw_last_i (cfg.fw_last),
    .left_o    (left_al),
    .right_o   (right_al)
  );

  // result assembly; an empty frame reports zeros
  always_comb begin
    if (!box.found_col) begin
      res_d = '0;
      res_d.empty_res = 1'b1;
    end else begin
      res_d.empty_res = 1'b0;
      res_d.row_first = XW'(box.top_row)    & XW'({WIN_W{1'b1}});
      res_d.row_last  = XW'(box.bottom_row) & XW'({WIN_W{1'b1}});
      res_d.col_first = XW'(left_al)        & XW'({WIN_W{1'b1}});
      res_d.col_last  = XW'(right_al)       & XW'({WIN_W{1'b1}});
    end
  end

  // output register
  assign out_valid_d = out_load ? 1'b1 : ((out_valid_q && !out_stall_i) ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign empty_res_o = res_q.empty_res;
  assign row_first_o = res_q.row_first;
  assign row_last_o  = res_q.row_last;
  assign col_first_o = res_q.col_first;
  assign col_last_o  = res_q.col_last;

  // a stalled result is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !out_load)
    else $error("result overwritten while stalled");

  // input stall only with a pixel held
  a_stall_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q)
    else $error("input stalled with empty input register");

  // a loaded result is presented next cycle
  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_valid_o)
    else $error("loaded result not presented");

  // a stalled pixel stays in the input register
  a_pixel_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> (in_valid_q && $stable(pixel_q)))
    else $error("stalled pixel lost");

endmodule

/* hdl/bbb_cfg.sv */
// ----------------------------------------------------------------------------
// bbb_cfg: configuration registers
// Holds the geometry and search windows; geometry is stored as clamped
// last-index values so the datapath needs no clamping per pixel.
// ----------------------------------------------------------------------------
module bbb_cfg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [bbb_pkg::IDX_W-1:0]  cfg_idx_i,
  input  logic [bbb_pkg::CFG_W-1:0]  cfg_data_i,
  output bbb_pkg::bbb_cfg_t          cfg_o
);
  import bbb_pkg::*;

  bbb_cfg_t cfg_q, cfg_d;

  // register decode
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (bbb_reg_e'(cfg_idx_i))
        REG_FRAME_WIDTH:  cfg_d.fw_last = COL_W'(clamp_last(cfg_data_i, MAX_WIDTH));
        REG_FRAME_HEIGHT: cfg_d.fh_last = ROW_W'(clamp_last(cfg_data_i, MAX_HEIGHT));
        REG_WIN_X_LO:     cfg_d.x_lo    = cfg_data_i[WIN_W-1:0];
        REG_WIN_X_HI:     cfg_d.x_hi    = cfg_data_i[WIN_W-1:0];
        REG_WIN_Y_LO:     cfg_d.y_lo    = cfg_data_i[WIN_W-1:0];
        REG_WIN_Y_HI:     cfg_d.y_hi    = cfg_data_i[WIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fw_last <= COL_W'(clamp_last(CFG_W'(1024), MAX_WIDTH));
      cfg_q.fh_last <= ROW_W'(clamp_last(CFG_W'(1024), MAX_HEIGHT));
      cfg_q.x_lo    <= '0;
      cfg_q.x_hi    <= '1;
      cfg_q.y_lo    <= '0;
      cfg_q.y_hi    <= '1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* hdl/bbb_track.sv */
// ----------------------------------------------------------------------------
// bbb_track: raster counters and bounding box tracking
// Counts column and row, updates the row and column edges for one pixel per
// advance, and presents the box seen at the last pixel of the frame.
// ----------------------------------------------------------------------------
module bbb_track (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  bbb_pkg::bbb_cfg_t          cfg_i,
  input  logic                       advance_i,
  input  logic [bbb_pkg::PIX_W-1:0]  pixel_i,
  input  logic                       frame_start_i,
  output logic                       is_last_o,
  output bbb_pkg::bbb_box_t          box_o
);
  import bbb_pkg::*;

  logic [COL_W-1:0] col_count_q, col_count_d;
  logic [ROW_W-1:0] row_count_q, row_count_d;
  logic             found_row_q, found_row_d;
  logic [ROW_W-1:0] top_row_q, top_row_d;
  logic [ROW_W-1:0] bottom_row_q, bottom_row_d;
  logic             found_col_q, found_col_d;
  logic [COL_W-1:0] left_col_q, left_col_d;
  logic [COL_W-1:0] right_col_q, right_col_d;

  logic [COL_W-1:0] c_base, c;
  logic [ROW_W-1:0] r_base, r;
  logic [XW-1:0]    cx, rx;
  logic             non_blank, row_ge_lo, row_le_hi, col_in_win;
  logic             col_end;

  // effective position: frame start restarts, shrunk geometry pins to last
  always_comb begin
    c_base = frame_start_i ? '0 : col_count_q;
    r_base = frame_start_i ? '0 : row_count_q;
    c      = (c_base > cfg_i.fw_last) ? cfg_i.fw_last : c_base;
    r      = (r_base > cfg_i.fh_last) ? cfg_i.fh_last : r_base;
    cx     = XW'(c);
    rx     = XW'(r);
  end

  assign non_blank  = (pixel_i != BLANK_PIX);
  assign row_ge_lo  = (rx >= XW'(cfg_i.y_lo));
  assign row_le_hi  = (rx <= XW'(cfg_i.y_hi));
  assign col_in_win = (cx >= XW'(cfg_i.x_lo)) && (cx <= XW'(cfg_i.x_hi));
  assign col_end    = (c == cfg_i.fw_last);
  assign is_last_o  = col_end && (r == cfg_i.fh_last);

  // edge update for this pixel, from cleared state on frame start
  always_comb begin
    found_row_d  = frame_start_i ? 1'b0 : found_row_q;
    top_row_d    = frame_start_i ? '0   : top_row_q;
    bottom_row_d = frame_start_i ? '0   : bottom_row_q;
    found_col_d  = frame_start_i ? 1'b0 : found_col_q;
    left_col_d   = frame_start_i ? '1   : left_col_q;
    right_col_d  = frame_start_i ? '0   : right_col_q;

    if (non_blank) begin
      if (!found_row_d && row_ge_lo) begin
        found_row_d = 1'b1;
        top_row_d   = r;
      end
      if (row_le_hi) begin
        bottom_row_d = r;
      end
      if (row_ge_lo && row_le_hi && col_in_win) begin
        if (!found_col_d || c < left_col_d) left_col_d = c;
        if (!found_col_d || c > right_col_d) right_col_d = c;
        found_col_d = 1'b1;
      end
    end
  end

  // box including the current pixel
  assign box_o.found_col  = found_col_d;
  assign box_o.top_row    = top_row_d;
  assign box_o.bottom_row = bottom_row_d;
  assign box_o.left_col   = left_col_d;
  assign box_o.right_col  = right_col_d;

  // raster counters
  always_comb begin
    if (is_last_o) begin
      col_count_d = '0;
      row_count_d = '0;
    end else if (col_end) begin
      col_count_d = '0;
      row_count_d = r + ROW_W'(1);
    end else begin
      col_count_d = c + COL_W'(1);
      row_count_d = r;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_count_q  <= '0;
      row_count_q  <= '0;
      found_row_q  <= 1'b0;
      top_row_q    <= '0;
      bottom_row_q <= '0;
      found_col_q  <= 1'b0;
      left_col_q   <= '1;
      right_col_q  <= '0;
    end else if (advance_i) begin
      col_count_q <= col_count_d;
      row_count_q <= row_count_d;
      if (is_last_o) begin
        // frame done: clear tracking for a following frame
        found_row_q  <= 1'b0;
        top_row_q    <= '0;
        bottom_row_q <= '0;
        found_col_q  <= 1'b0;
        left_col_q   <= '1;
        right_col_q  <= '0;
      end else begin
        found_row_q  <= found_row_d;
        top_row_q    <= top_row_d;
        bottom_row_q <= bottom_row_d;
        found_col_q  <= found_col_d;
        left_col_q   <= left_col_d;
        right_col_q  <= right_col_d;
      end
    end
  end

endmodule

/* hdl/bbb_align.sv */
// ----------------------------------------------------------------------------
// bbb_align: column edge alignment
// Widens the column span to a multiple of ALIGN by lowering the left edge,
// spilling any shortfall below zero onto the right edge, then saturates the
// right edge at the last column.
// ----------------------------------------------------------------------------
module bbb_align (
  input  logic [bbb_pkg::COL_W-1:0] left_i,
  input  logic [bbb_pkg::COL_W-1:0] right_i,
  input  logic [bbb_pkg::COL_W-1:0] fw_last_i,
  output logic [bbb_pkg::COL_W-1:0] left_o,
  output logic [bbb_pkg::COL_W-1:0] right_o
);
  import bbb_pkg::*;

  logic [EXT_W-1:0] left_x, right_x, span, rem, pad, right_a, left_a;

  always_comb begin
    left_x  = EXT_W'(left_i);
    right_x = EXT_W'(right_i);
    span    = right_x - left_x + EXT_W'(1);
    rem     = span & EXT_W'(ALIGN - 1);
    pad     = (rem == '0) ? '0 : (EXT_W'(ALIGN) - rem);
    // padding deeper than the left edge moves the right edge up instead
    if (pad > left_x) begin
      left_a  = '0;
      right_a = right_x + (pad - left_x);
    end else begin
      left_a  = left_x - pad;
      right_a = right_x;
    end
    if (right_a > EXT_W'(fw_last_i)) begin
      right_a = EXT_W'(fw_last_i);
    end
    left_o  = left_a[COL_W-1:0];
    right_o = right_a[COL_W-1:0];
  end

endmodule

/* tb/sv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: self-checking bench for blank_border_bounding_box
// Streams raster frames of random and hand-picked content through the pixel
// channel, predicts each frame's box from a shadow of the registers and the
// tracking state, and checks every result transaction field by field. Both
// channels idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
  import bbb_pkg::*;

  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_PIXELS = 400;

  // spare register indexes: writes there must be ignored
  localparam logic [IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [IDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef enum int {IDLE_NONE, IDLE_LIGHT, IDLE_FULL} idle_e;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0] cfg_data_i;
  logic             in_valid_i;
  logic             in_stall_o;
  logic [PIX_W-1:0] pixel_i;
  logic             frame_start_i;
  logic             out_valid_o;
  logic             out_stall_i;
  logic             empty_res_o;
  logic [WIN_W-1:0] row_first_o;
  logic [WIN_W-1:0] row_last_o;
  logic [WIN_W-1:0] col_first_o;
  logic [WIN_W-1:0] col_last_o;

  blank_border_bounding_box DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .pixel_i      (pixel_i),
    .frame_start_i(frame_start_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .empty_res_o  (empty_res_o),
    .row_first_o  (row_first_o),
    .row_last_o   (row_last_o),
    .col_first_o  (col_first_o),
    .col_last_o   (col_last_o)
  );

  // shadow registers
  logic [CFG_W-1:0] sh_width, sh_height;
  logic [WIN_W-1:0] sh_xlo, sh_xhi, sh_ylo, sh_yhi;

  // shadow tracking state
  int col_cnt, row_cnt, top_row, bot_row, left_col, right_col;
  bit row_hit, col_hit;

  bbb_res_t box_q[$];
  bbb_res_t want_box;
  int       errors;
  int       cycle_cnt;
  int       pixels_sent;
  int       rx_wait;
  idle_e    tx_mode, rx_mode;

  // clock
  initial clk_i = 1'b0;
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d boxes outstanding", $time, box_q.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic int draw_wait(idle_e m);
    int n;
    case (m)
      IDLE_NONE:  n = 0;
      IDLE_LIGHT: n = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 11) : 0;
      default:    n = $urandom_range(0, 11);
    endcase
    return n;
  endfunction

  // 0 counts as 1, anything above the maximum as the maximum
  function automatic int dim_clamp(logic [CFG_W-1:0] v, int maxv);
    int d;
    if (v == '0) d = 1;
    else if (int'(v) > maxv) d = maxv;
    else d = int'(v);
    return d;
  endfunction

  function automatic void clear_tracking();
    col_cnt   = 0;
    row_cnt   = 0;
    row_hit   = 1'b0;
    top_row   = 0;
    bot_row   = 0;
    col_hit   = 1'b0;
    left_col  = (1 << WIN_W) - 1;
    right_col = 0;
  endfunction

  // box predictor: update tracking for one accepted pixel
  function automatic void predict_pixel(logic [PIX_W-1:0] pix, logic fs);
    int       fw, fh, c, r, lft, rgt, rem;
    bbb_res_t box;
    fw = dim_clamp(sh_width, MAX_WIDTH);
    fh = dim_clamp(sh_height, MAX_HEIGHT);
    if (fs) clear_tracking();
    // geometry may have shrunk under a partial frame
    if (col_cnt >= fw) col_cnt = fw - 1;
    if (row_cnt >= fh) row_cnt = fh - 1;
    c = col_cnt;
    r = row_cnt;

    if (pix != BLANK_PIX) begin
      if (!row_hit && r >= int'(sh_ylo)) begin
        row_hit = 1'b1;
        top_row = r;
      end
      if (r <= int'(sh_yhi)) bot_row = r;
      if (r >= int'(sh_ylo) && r <= int'(sh_yhi) &&
          c >= int'(sh_xlo) && c <= int'(sh_xhi)) begin
        if (!col_hit || c < left_col) left_col = c;
        if (!col_hit || c > right_col) right_col = c;
        col_hit = 1'b1;
      end
    end

    if (c == fw - 1 && r == fh - 1) begin
      box = '0;
      if (!col_hit) begin
        box.empty_res = 1'b1;
      end else begin
        lft = left_col;
        rgt = right_col;
        rem = (rgt - lft + 1) % ALIGN;
        // widen to the alignment, spilling right when the left runs out
        if (rem != 0) begin
          lft -= ALIGN - rem;
          if (lft < 0) begin
            rgt -= lft;
            lft = 0;
          end
        end
        if (rgt > fw - 1) rgt = fw - 1;
        box.row_first = WIN_W'(top_row);
        box.row_last  = WIN_W'(bot_row);
        box.col_first = WIN_W'(lft);
        box.col_last  = WIN_W'(rgt);
      end
      box_q.push_back(box);
      clear_tracking();
    end else if (c == fw - 1) begin
      col_cnt = 0;
      row_cnt = r + 1;
    end else begin
      col_cnt = c + 1;
    end
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (box_q.size() == 0) begin
        $display("%0t: unexpected result transaction, expected none got %b %0d %0d %0d %0d",
                 $time, empty_res_o, row_first_o, row_last_o, col_first_o, col_last_o);
        errors++;
      end else begin
        want_box = box_q.pop_front();
        check_field("empty_res", want_box.empty_res, empty_res_o);
        check_field("row_first", want_box.row_first, row_first_o);
        check_field("row_last", want_box.row_last, row_last_o);
        check_field("col_first", want_box.col_first, col_first_o);
        check_field("col_last", want_box.col_last, col_last_o);
      end
    end
  end

  // result side: random stall before each transaction
  initial begin
    forever begin
      rx_wait = draw_wait(rx_mode);
      repeat (rx_wait) begin
        @(negedge clk_i);
        out_stall_i <= 1'b1;
      end
      @(negedge clk_i);
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // one pixel transaction, with a random gap ahead of it
  task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic fs);
    int gap;
    gap = draw_wait(tx_mode);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    pixel_i       <= pix;
    frame_start_i <= fs;
    do @(posedge clk_i); while (in_stall_o);
    predict_pixel(pix, fs);
    pixels_sent++;
  endtask

  function automatic logic [PIX_W-1:0] rand_pixel(int density);
    logic [PIX_W-1:0] p;
    if ($urandom_range(0, 99) < density) p = PIX_W'($urandom_range(0, 254));
    else p = BLANK_PIX;
    return p;
  endfunction

  task automatic send_frame(input int w, input int h, input int density, input logic fs);
    for (int i = 0; i < w * h; i++) send_pixel(rand_pixel(density), fs && i == 0);
  endtask

  // frame that is blank except at linear positions p0 and p1 (-1: none)
  task automatic send_sparse(input int w, input int h, input int p0, input int p1,
                             input logic [PIX_W-1:0] v, input logic fs);
    for (int i = 0; i < w * h; i++)
      send_pixel((i == p0 || i == p1) ? v : BLANK_PIX, fs && i == 0);
  endtask

  // drop valid, wait for every box, then let the pipeline empty
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (box_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    case (idx)
      REG_FRAME_WIDTH:  sh_width  = val;
      REG_FRAME_HEIGHT: sh_height = val;
      REG_WIN_X_LO:     sh_xlo    = val[WIN_W-1:0];
      REG_WIN_X_HI:     sh_xhi    = val[WIN_W-1:0];
      REG_WIN_Y_LO:     sh_ylo    = val[WIN_W-1:0];
      REG_WIN_Y_HI:     sh_yhi    = val[WIN_W-1:0];
      default: ;
    endcase
  endtask

  task automatic cfg_end();
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic configure(input int fw, input int fh, input int xlo, input int xhi,
                           input int ylo, input int yhi);
    write_reg(REG_FRAME_WIDTH, CFG_W'(fw));
    write_reg(REG_FRAME_HEIGHT, CFG_W'(fh));
    write_reg(REG_WIN_X_LO, CFG_W'(xlo));
    write_reg(REG_WIN_X_HI, CFG_W'(xhi));
    write_reg(REG_WIN_Y_LO, CFG_W'(ylo));
    write_reg(REG_WIN_Y_HI, CFG_W'(yhi));
    cfg_end();
  endtask

  // window registers keep their reset values here
  task automatic test_defaults();
    tx_mode = IDLE_FULL;
    rx_mode = IDLE_FULL;
    write_reg(REG_FRAME_WIDTH, 11'd4);
    write_reg(REG_FRAME_HEIGHT, 11'd1);
    cfg_end();
    send_sparse(4, 1, 1, -1, 8'h5a, 1'b1);
    settle();
  endtask

  // alignment cases, restart and back-to-back frames
  task automatic test_alignment();
    configure(4, 1, 0, 1023, 0, 1023);
    send_sparse(4, 1, -1, -1, 8'h00, 1'b1);      // all blank: empty box
    send_sparse(4, 1, 0, -1, 8'h00, 1'b1);       // left edge runs below zero
    send_sparse(4, 1, 2, -1, 8'hfe, 1'b1);
    send_sparse(4, 1, 3, -1, 8'h80, 1'b0);       // no frame start
    send_pixel(8'h01, 1'b1);                     // abandoned frame
    send_pixel(8'h02, 1'b0);
    send_sparse(4, 1, 3, -1, 8'h7f, 1'b1);       // restart mid-frame
    settle();
    configure(5, 1, 0, 1023, 0, 1023);
    send_sparse(5, 1, 0, 4, 8'h33, 1'b1);        // right edge saturates
    settle();
    configure(0, 0, 0, 1023, 0, 1023);           // clamps to a 1x1 frame
    send_pixel(8'h10, 1'b1);
    send_pixel(BLANK_PIX, 1'b0);
    send_pixel(8'hc3, 1'b0);
    settle();
  endtask

  // writes to indexes outside the register file change nothing
  task automatic test_spare_index();
    configure(4, 2, 1, 2, 0, 1);
    write_reg(REG_SPARE_LO, 11'h7ff);
    write_reg(REG_SPARE_HI, 11'h000);
    cfg_end();
    send_frame(4, 2, 50, 1'b1);
    settle();
  endtask

  // row and column windows, including inverted ones
  task automatic test_windows();
    tx_mode = IDLE_LIGHT;
    rx_mode = IDLE_FULL;
    configure(8, 4, 2, 5, 1, 2);
    send_frame(8, 4, 30, 1'b1);
    send_frame(8, 4, 90, 1'b1);
    settle();
    configure(8, 4, 5, 2, 0, 3);                 // inverted column window
    send_frame(8, 4, 60, 1'b1);
    settle();
    configure(8, 4, 0, 7, 3, 1);                 // inverted row window
    send_frame(8, 4, 60, 1'b1);
    settle();
    configure(8, 4, 1023, 1023, 1023, 1023);     // windows beyond the frame
    send_frame(8, 4, 60, 1'b1);
    settle();
  endtask

  // frames narrower than the alignment and single-column frames
  task automatic test_geometry();
    tx_mode = IDLE_NONE;
    rx_mode = IDLE_LIGHT;
    configure(3, 2, 0, 1023, 0, 1023);
    send_sparse(3, 2, 1, 5, 8'h44, 1'b1);        // padding runs past the last column
    send_frame(3, 2, 50, 1'b0);
    settle();
    configure(1, 3, 0, 1023, 0, 1023);
    send_frame(1, 3, 70, 1'b1);
    send_frame(1, 3, 70, 1'b0);
    settle();
  endtask

  // random settings and frames, with partial frames and stray frame starts
  task automatic test_random();
    int w, h, xlo, xhi, ylo, yhi, fw, fh, target, start, act, n;
    int dens[4];
    dens = '{2, 10, 40, 90};
    start = pixels_sent;
    while (pixels_sent < start + RANDOM_PIXELS) begin
      settle();
      case ($urandom_range(0, 9))
        0:       w = 4;
        1:       w = $urandom_range(0, 3);
        default: w = $urandom_range(4, 12);
      endcase
      h = ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(1, 6);
      fw = dim_clamp(CFG_W'(w), MAX_WIDTH);
      fh = dim_clamp(CFG_W'(h), MAX_HEIGHT);
      case ($urandom_range(0, 5))
        0:       begin xlo = 0; xhi = 1023; end
        1:       begin xhi = $urandom_range(0, fw - 1); xlo = $urandom_range(xhi, fw + 1); end
        default: begin xlo = $urandom_range(0, fw - 1); xhi = $urandom_range(xlo, fw + 1); end
      endcase
      case ($urandom_range(0, 5))
        0:       begin ylo = 0; yhi = 1023; end
        1:       begin yhi = $urandom_range(0, fh - 1); ylo = $urandom_range(yhi, fh + 1); end
        default: begin ylo = $urandom_range(0, fh - 1); yhi = $urandom_range(ylo, fh + 1); end
      endcase
      configure(w, h, xlo, xhi, ylo, yhi);
      tx_mode = idle_e'($urandom_range(0, 2));
      rx_mode = idle_e'($urandom_range(0, 2));
      target = pixels_sent + $urandom_range(60, 140);
      while (pixels_sent < target) begin
        act = $urandom_range(0, 99);
        if (act < 80) begin
          // whole frame; may follow the previous one without a start mark
          send_frame(fw, fh, dens[$urandom_range(0, 3)],
                     (col_cnt != 0 || row_cnt != 0) || $urandom_range(0, 2) != 0);
        end else if (act < 90) begin
          // broken frame: cut short, the next one restarts
          n = (fw * fh > 1) ? $urandom_range(1, fw * fh - 1) : 1;
          send_frame(n, 1, dens[$urandom_range(0, 3)], 1'b1);
        end else if (act < 95) begin
          settle();                              // hold off until drained
        end else begin
          send_pixel(rand_pixel(50), $urandom_range(0, 3) == 0);
        end
      end
    end
    settle();
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_data_i    = '0;
    in_valid_i    = 1'b0;
    pixel_i       = BLANK_PIX;
    frame_start_i = 1'b0;
    out_stall_i   = 1'b0;
    errors        = 0;
    cycle_cnt     = 0;
    pixels_sent   = 0;
    tx_mode       = IDLE_NONE;
    rx_mode       = IDLE_NONE;
    sh_width      = 11'd1024;
    sh_height     = 11'd1024;
    sh_xlo        = '0;
    sh_xhi        = 10'd1023;
    sh_ylo        = '0;
    sh_yhi        = 10'd1023;
    clear_tracking();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_defaults();
    test_alignment();
    test_spare_index();
    test_windows();
    test_geometry();
    test_random();

    settle();
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
